/* hw/rtl/dedup_request_queue_top_macros.svh */
`ifndef DEDUP_REQUEST_QUEUE_TOP_MACROS_SVH
`define DEDUP_REQUEST_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define DQR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define DQR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dqr_pkg.sv */
package dqr_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 8;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 2 * VALUE_BITS;

  typedef enum logic [1:0] {
    MODE_PUSH,
    MODE_POP,
    MODE_REMOVE,
    MODE_NONE
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_DUP,
    STAT_FULL,
    STAT_EMPTY,
    STAT_NOTFOUND
  } status_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] start_req;
    logic [7:0] destination;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic       head_valid;
    logic [7:0] head_start;
    logic [7:0] head_destination;
    logic [4:0] count;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

/* hw/rtl/dqr_ram.sv */
module dqr_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [DEPTH_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [DEPTH_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**DEPTH_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dqr_ctrl.sv */
module dqr_ctrl
  import dqr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmd_t               cmd,
  output logic               res_valid,
  output result_t            res,
  input  logic               res_take,
  output ram_req_t           ram_req,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t             state;
  mode_t              mode;
  status_t            status;
  logic [ENTRY_W-1:0] key;
  logic [ENTRY_W-1:0] head;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   occ;

  mode_t              cmd_mode;
  logic [ENTRY_W-1:0] key_in;
  logic [CNT_W-1:0]   occ_m1;
  logic [CNT_W-1:0]   idx_ext;
  logic               hit;
  logic               at_last;
  logic               shift_last;
  logic               full;

  assign cmd_mode   = mode_t'(cmd.mode);
  assign key_in     = {VALUE_BITS'(cmd.start_req), VALUE_BITS'(cmd.destination)};
  assign occ_m1     = occ - CNT_W'(1);
  assign idx_ext    = CNT_W'(idx);
  assign hit        = (ram_rdata == key);
  assign at_last    = (idx_ext == occ_m1);
  assign shift_last = ((idx_ext + CNT_W'(1)) == occ_m1);
  assign full       = (occ == CNT_W'(DEPTH));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status           = status;
    res.head_valid       = (occ != '0);
    res.head_start       = (occ != '0) ? 8'(head[ENTRY_W-1:VALUE_BITS]) : 8'd0;
    res.head_destination = (occ != '0) ? 8'(head[VALUE_BITS-1:0]) : 8'd0;
    res.count            = 5'(occ);
  end

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = idx;
    ram_req.wdata = key;
    ram_req.raddr = idx + IDX_W'(1);
    case (state)
      S_IDLE: begin
        ram_req.raddr = (cmd_mode == MODE_POP) ? IDX_W'(1) : '0;
        ram_req.wdata = key_in;
        ram_req.waddr = '0;
        ram_req.we    = in_valid && (cmd_mode == MODE_PUSH) && (occ == '0);
      end
      S_SCAN: begin
        ram_req.waddr = IDX_W'(occ);
        ram_req.we    = !hit && at_last && (mode == MODE_PUSH) && !full;
      end
      S_SHIFT: begin
        ram_req.raddr = idx + IDX_W'(2);
        ram_req.wdata = ram_rdata;
        ram_req.we    = 1'b1;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode   <= cmd_mode;
            key    <= key_in;
            idx    <= '0;
            status <= STAT_OK;
            case (cmd_mode)
              MODE_PUSH: begin
                if (occ == '0) begin
                  occ   <= CNT_W'(1);
                  head  <= key_in;
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              MODE_POP: begin
                if (occ == '0) begin
                  status <= STAT_EMPTY;
                  state  <= S_DONE;
                end else if (occ == CNT_W'(1)) begin
                  occ   <= '0;
                  state <= S_DONE;
                end else begin
                  state <= S_SHIFT;
                end
              end
              MODE_REMOVE: begin
                if (occ == '0) begin
                  status <= STAT_EMPTY;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (mode == MODE_PUSH) begin
              status <= STAT_DUP;
              state  <= S_DONE;
            end else if (at_last) begin
              occ   <= occ_m1;
              state <= S_DONE;
            end else begin
              state <= S_SHIFT;
            end
          end else if (at_last) begin
            if (mode == MODE_PUSH) begin
              if (full) begin
                status <= STAT_FULL;
              end else begin
                occ <= occ + CNT_W'(1);
              end
            end else begin
              status <= STAT_NOTFOUND;
            end
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_SHIFT: begin
          if (idx == '0) begin
            head <= ram_rdata;
          end
          if (shift_last) begin
            occ   <= occ_m1;
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/dedup_request_queue_top.sv */
// Mode 3, pop or remove on an empty queue, push on an empty queue and pop of the last
// entry go straight from idle to the done state; other requests pass through the scan
// state, the shift state or both, as a search reads one entry per cycle and a pop or
// removal shifts the tail. A finished result waits in the done state until the output
// register is free; the next request is accepted only once the result has moved there.
// Reset: synchronous active-high rst empties the queue; entry storage is not cleared.
`include "dedup_request_queue_top_macros.svh"

module dedup_request_queue_top
  import dqr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // mode[1:0], start_req[9:2], destination[17:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[2:0], head_valid[3], head_start[11:4],
                                 // head_destination[19:12], count[24:20]
);

  cmd_t               cmd;
  result_t            res;
  result_t            out_res;
  logic               res_valid;
  logic               res_take;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               out_empty;
  logic               out_dup;

  assign cmd.mode        = s_tdata[1:0];
  assign cmd.start_req   = s_tdata[9:2];
  assign cmd.destination = s_tdata[17:10];

  assign res_take = res_valid && (!m_tvalid || m_tready);

  dqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  dqr_ram #(
    .DATA_W  (ENTRY_W),
    .DEPTH_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.count, out_res.head_destination, out_res.head_start,
                    out_res.head_valid, out_res.status};

  assign out_empty = m_tvalid && (out_res.status == STAT_EMPTY);
  assign out_dup   = m_tvalid && (out_res.status == STAT_DUP);

  `DQR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "busy after accept")
  `DQR_ASSERT_IMPL(a_empty_no_head, out_empty, !out_res.head_valid, "empty status with head")
  `DQR_ASSERT_IMPL(a_dup_has_head, out_dup, out_res.head_valid, "duplicate on empty queue")

endmodule
